// File: rtl/ccs_pkg.sv
// Shared constants, types and helpers for the C comment stripper.
`default_nettype none

package ccs_pkg;

	localparam int MODE_W = 3;
	localparam int CHAR_W = 8;
	localparam int OUT_DEPTH = 4;

	localparam logic [MODE_W-1:0] MODE_NORMAL      = 3'd0;
	localparam logic [MODE_W-1:0] MODE_AFTER_SLASH = 3'd1;
	localparam logic [MODE_W-1:0] MODE_STRING      = 3'd2;
	localparam logic [MODE_W-1:0] MODE_CHAR        = 3'd3;
	localparam logic [MODE_W-1:0] MODE_LINE        = 3'd4;
	localparam logic [MODE_W-1:0] MODE_BLOCK       = 3'd5;

	localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
	localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
	localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
	localparam logic [CHAR_W-1:0] CH_BSL   = 8'h5C;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_DQ    = 8'h22;
	localparam logic [CHAR_W-1:0] CH_SQ    = 8'h27;

	// results of one byte, handed from the lexer to the output queue
	typedef struct packed {
		logic              valid;
		logic              two;
		logic [CHAR_W-1:0] c0;
		logic [CHAR_W-1:0] c1;
	} push_t;

	function automatic logic [CHAR_W-1:0] map_normal(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] r;
		r = c;
		if (c == CH_NL) begin
			r = CH_SPACE;
		end else if (c == CH_SEMI) begin
			r = CH_NL;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/ccs_in_if.sv
// Input byte channel of the comment stripper.
`default_nettype none

interface ccs_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;

	modport source (output valid, output in_char, input ready);
	modport sink (input valid, input in_char, output ready);
endinterface

`default_nettype wire

// File: rtl/ccs_out_if.sv
// Output byte channel of the comment stripper.
`default_nettype none

interface ccs_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       last_of_run;

	modport source (output valid, output out_char, output last_of_run, input ready);
	modport sink (input valid, input out_char, input last_of_run, output ready);
endinterface

`default_nettype wire

// File: rtl/ccs_lexer.sv
// Input register and lexer state: turns one byte into zero, one or two result bytes.
`default_nettype none

module ccs_lexer (
	input  wire logic     clk,
	input  wire logic     arst_n,
	ccs_in_if.sink        text_in,
	input  wire logic     space_ok,
	output ccs_pkg::push_t push
);

	logic                          valid_s1;
	logic [ccs_pkg::CHAR_W-1:0]    char_s1;
	logic [ccs_pkg::MODE_W-1:0]    mode_q;
	logic                          esc_q;
	logic                          star_q;

	logic [ccs_pkg::MODE_W-1:0]    mode_d;
	logic                          esc_d;
	logic                          star_d;
	logic                          one;
	logic                          two;
	logic [ccs_pkg::CHAR_W-1:0]    c0;
	logic [ccs_pkg::CHAR_W-1:0]    c1;
	logic [ccs_pkg::CHAR_W-1:0]    quote;
	logic                          adv;

	assign adv = valid_s1 && space_ok;
	assign text_in.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_in.ready) begin
			valid_s1 <= text_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_in.ready && text_in.valid) begin
			char_s1 <= text_in.in_char;
		end
	end

	always_comb begin
		mode_d = mode_q;
		esc_d  = esc_q;
		star_d = star_q;
		one    = 1'b0;
		two    = 1'b0;
		c0     = char_s1;
		c1     = ccs_pkg::map_normal(char_s1);
		quote  = (mode_q == ccs_pkg::MODE_STRING) ? ccs_pkg::CH_DQ : ccs_pkg::CH_SQ;
		case (mode_q)
			ccs_pkg::MODE_AFTER_SLASH: begin
				if (char_s1 == ccs_pkg::CH_SLASH) begin
					mode_d = ccs_pkg::MODE_LINE;
					esc_d  = 1'b0;
				end else if (char_s1 == ccs_pkg::CH_STAR) begin
					mode_d = ccs_pkg::MODE_BLOCK;
					star_d = 1'b0;
				end else begin
					// lone slash: emit it, then the byte as normal text
					two    = 1'b1;
					c0     = ccs_pkg::CH_SLASH;
					mode_d = ccs_pkg::MODE_NORMAL;
					if (char_s1 == ccs_pkg::CH_DQ) begin
						mode_d = ccs_pkg::MODE_STRING;
						esc_d  = 1'b0;
					end else if (char_s1 == ccs_pkg::CH_SQ) begin
						mode_d = ccs_pkg::MODE_CHAR;
						esc_d  = 1'b0;
					end
				end
			end
			ccs_pkg::MODE_STRING, ccs_pkg::MODE_CHAR: begin
				one = 1'b1;
				if (char_s1 == quote && !esc_q) begin
					mode_d = ccs_pkg::MODE_NORMAL;
				end
				esc_d = (char_s1 == ccs_pkg::CH_BSL) && !esc_q;
			end
			ccs_pkg::MODE_LINE: begin
				if (char_s1 == ccs_pkg::CH_NL && !esc_q) begin
					one    = 1'b1;
					c0     = ccs_pkg::CH_SPACE;
					mode_d = ccs_pkg::MODE_NORMAL;
				end
				esc_d = (char_s1 == ccs_pkg::CH_BSL) && !esc_q;
			end
			ccs_pkg::MODE_BLOCK: begin
				if (char_s1 == ccs_pkg::CH_SLASH && star_q) begin
					one    = 1'b1;
					c0     = ccs_pkg::CH_SPACE;
					mode_d = ccs_pkg::MODE_NORMAL;
				end
				star_d = (char_s1 == ccs_pkg::CH_STAR);
			end
			default: begin
				mode_d = ccs_pkg::MODE_NORMAL;
				if (char_s1 == ccs_pkg::CH_SLASH) begin
					mode_d = ccs_pkg::MODE_AFTER_SLASH;
				end else begin
					one = 1'b1;
					c0  = ccs_pkg::map_normal(char_s1);
					if (char_s1 == ccs_pkg::CH_DQ) begin
						mode_d = ccs_pkg::MODE_STRING;
						esc_d  = 1'b0;
					end else if (char_s1 == ccs_pkg::CH_SQ) begin
						mode_d = ccs_pkg::MODE_CHAR;
						esc_d  = 1'b0;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ccs_pkg::MODE_NORMAL;
			esc_q  <= 1'b0;
			star_q <= 1'b0;
		end else if (adv) begin
			mode_q <= mode_d;
			esc_q  <= esc_d;
			star_q <= star_d;
		end
	end

	assign push.valid = adv && (one || two);
	assign push.two   = two;
	assign push.c0    = c0;
	assign push.c1    = c1;

	a_star_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		star_q |-> (mode_q == ccs_pkg::MODE_BLOCK))
		else $error("star flag set outside a block comment");

	a_esc_in_lit: assert property (@(posedge clk) disable iff (!arst_n)
		esc_q |-> (mode_q == ccs_pkg::MODE_STRING || mode_q == ccs_pkg::MODE_CHAR ||
			mode_q == ccs_pkg::MODE_LINE))
		else $error("escape flag set outside a literal or line comment");

	a_two_slash: assert property (@(posedge clk) disable iff (!arst_n)
		(push.valid && push.two) |-> ($past(mode_q) == ccs_pkg::MODE_AFTER_SLASH ||
			mode_q == ccs_pkg::MODE_AFTER_SLASH) && push.c0 == ccs_pkg::CH_SLASH)
		else $error("two results without a pending slash");

endmodule

`default_nettype wire

// File: rtl/ccs_out_q.sv
// Queue of result bytes: takes one or two per cycle, pops one when ready.
`default_nettype none

module ccs_out_q #(
	parameter int DEPTH = ccs_pkg::OUT_DEPTH
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  ccs_pkg::push_t push,
	output logic           space_ok,
	ccs_out_if.source      text_out
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [ccs_pkg::CHAR_W:0] mem_q [DEPTH];
	logic [PW-1:0]            wr_q;
	logic [PW-1:0]            rd_q;
	logic [CW-1:0]            count_q;
	logic [PW-1:0]            wr_nx;
	logic                     pop;
	logic [1:0]               n_push;

	function automatic logic [PW-1:0] step(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign wr_nx    = step(wr_q);
	assign pop      = text_out.valid && text_out.ready;
	assign space_ok = count_q <= CW'(DEPTH - 2);
	assign n_push   = !push.valid ? 2'd0 : (push.two ? 2'd2 : 2'd1);

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_q] <= {!push.two, push.c0};
			if (push.two) begin
				mem_q[wr_nx] <= {1'b1, push.c1};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push.valid) begin
				wr_q <= push.two ? step(wr_nx) : wr_nx;
			end
			if (pop) begin
				rd_q <= step(rd_q);
			end
			count_q <= count_q + CW'(n_push) - CW'(pop);
		end
	end

	assign text_out.valid       = count_q != '0;
	assign text_out.out_char    = mem_q[rd_q][ccs_pkg::CHAR_W-1:0];
	assign text_out.last_of_run = mem_q[rd_q][ccs_pkg::CHAR_W];

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> count_q <= CW'(DEPTH - 2))
		else $error("push into queue without room for two bytes");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");

	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push.valid) |=> count_q == $past(count_q) - 1'b1)
		else $error("queue count wrong after a lone transfer out");

endmodule

`default_nettype wire

// File: rtl/c_comment_stripper.sv
// Top level of the C comment stripper: lexer stage feeding an output queue.
// An accepted byte goes to the input register, then into the output queue, then out.
// Throughput: one byte per cycle; a byte with two results needs two output transfers,
// and input stalls while the output queue holds fewer than two free entries.
// Reset (arst_n low, asynchronous): normal text mode, escape and star flags clear,
// input stage and output queue empty.
`default_nettype none

module c_comment_stripper #(
	parameter int OUT_DEPTH = ccs_pkg::OUT_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	ccs_in_if.sink    text_in,
	ccs_out_if.source text_out
);

	ccs_pkg::push_t push;
	logic           space_ok;

	ccs_lexer u_lexer (
		.clk      (clk),
		.arst_n   (arst_n),
		.text_in  (text_in),
		.space_ok (space_ok),
		.push     (push)
	);

	ccs_out_q #(
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.space_ok (space_ok),
		.text_out (text_out)
	);

endmodule

`default_nettype wire
